// ===== sv/lowest_free_id_bitmap_allocator_core_assert.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef LOWEST_FREE_ID_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define LOWEST_FREE_ID_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lfidalloc_pkg.sv =====
`default_nettype none

package lfidalloc_pkg;

    localparam int ID_COUNT_DEF  = 4096;
    localparam int WORD_BITS_DEF = 64;

    typedef logic [1:0] t_req;

    localparam t_req REQ_ALLOC  = 2'd0;
    localparam t_req REQ_FREE   = 2'd1;
    localparam t_req REQ_REINIT = 2'd2;

endpackage

`default_nettype wire

// ===== sv/lowest_free_id_bitmap_allocator_core.sv =====
// Channel      Signals                                  Transaction
// -----------  ---------------------------------------  ----------------------------------
// request      start, busy, i_req_type, i_release_id    start high while busy is low
// result       o_valid, o_granted_id, o_exhausted       o_valid high for one cycle
//
// An allocate keeps busy high while it scans from word 0 up to the map word that holds the
// granted id (all MAP_WORDS words when the map is full), reading one word per cycle; the
// result is on the outputs in the first cycle with busy low.
// A free of an id from 1 to ID_COUNT-1 keeps busy high for quotient correction and then
// the read-modify-write; other frees, reinitialize and code 3 finish at accept.
// Reset and reinitialize clear one valid flag per map word, and the receiver cannot stall.
`default_nettype none

module lowest_free_id_bitmap_allocator_core #(
    parameter int ID_COUNT  = lfidalloc_pkg::ID_COUNT_DEF,
    parameter int WORD_BITS = lfidalloc_pkg::WORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire lfidalloc_pkg::t_req         i_req_type,
    input  wire logic [$clog2(ID_COUNT)-1:0] i_release_id,
    output logic                             o_valid,
    output logic [$clog2(ID_COUNT)-1:0]      o_granted_id,
    output logic                             o_exhausted
);
    import lfidalloc_pkg::*;

    localparam int ID_W      = $clog2(ID_COUNT);
    localparam int MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int TAIL      = ID_COUNT - (MAP_WORDS - 1) * WORD_BITS;
    localparam int PW        = 2 * ID_W;
    localparam int RECIP     = (2 ** ID_W) / WORD_BITS;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_DIV,
        ST_FREE_WR
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_rd_addr;
    logic [AW-1:0]        n_rd_addr;
    logic [AW-1:0]        r_quot;
    logic [ID_W-1:0]      r_rel;
    logic [BW-1:0]        r_bit;
    logic                 r_valid;
    logic [ID_W-1:0]      r_granted_id;
    logic                 r_exhausted;

    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [MAP_WORDS-1:0] r_word_vld;

    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [BW-1:0]        found_bit;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;
    logic                 reinit;
    logic [PW-1:0]        quot_prod;
    logic [AW-1:0]        quot_est;
    logic [ID_W-1:0]      rem_raw;
    logic                 rem_over;
    logic [AW-1:0]        quot_fix;
    logic [ID_W-1:0]      rem_fix;
    logic                 accept;
    logic                 rel_ok;

    assign accept    = start && !busy;
    assign reinit    = accept && (i_req_type == REQ_REINIT);
    assign rel_ok    = (i_release_id != '0) &&
                       ((ID_W + 1)'(i_release_id) < (ID_W + 1)'(ID_COUNT));
    assign quot_prod = PW'(i_release_id) * PW'(RECIP);
    assign quot_est  = AW'(quot_prod >> ID_W);
    assign rem_raw   = r_rel - ID_W'(ID_W'(r_quot) * ID_W'(WORD_BITS));
    assign rem_over  = rem_raw >= ID_W'(WORD_BITS);
    assign quot_fix  = rem_over ? r_quot + AW'(1) : r_quot;
    assign rem_fix   = rem_over ? rem_raw - ID_W'(WORD_BITS) : rem_raw;

    assign word_cur = r_rd_vld ? r_rd_data :
                      ((r_rd_addr == '0) ? WORD_BITS'(1) : '0);

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            free_bits[i] = !word_cur[i] && ((r_rd_addr != LAST_WORD) || (i < TAIL));
        end
        found     = 1'b0;
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                found     = 1'b1;
                found_bit = BW'(i);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = word_cur;
        if (r_state == ST_SCAN && found) begin
            wr_en   = 1'b1;
            wr_data = word_cur | (WORD_BITS'(1) << found_bit);
        end else if (r_state == ST_FREE_WR) begin
            wr_en   = 1'b1;
            wr_data = word_cur & ~(WORD_BITS'(1) << r_bit);
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE:     n_rd_addr = '0;
            ST_SCAN:     n_rd_addr = r_rd_addr + AW'(1);
            ST_FREE_DIV: n_rd_addr = quot_fix;
            ST_FREE_WR:  n_rd_addr = r_rd_addr;
            default:     n_rd_addr = r_rd_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_rd_addr] <= wr_data;
        end
        r_rd_data <= r_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || reinit) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_word_vld[r_rd_addr] <= 1'b1;
            end
            r_rd_vld <= r_word_vld[n_rd_addr] || (wr_en && (r_rd_addr == n_rd_addr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_rd_addr <= n_rd_addr;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_req_type)
                            REQ_ALLOC: r_state <= ST_SCAN;
                            REQ_FREE: begin
                                r_quot <= quot_est;
                                r_rel  <= i_release_id;
                                if (rel_ok) begin
                                    r_state <= ST_FREE_DIV;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (found) begin
                        r_valid      <= 1'b1;
                        r_exhausted  <= 1'b0;
                        r_granted_id <= ID_W'(ID_W'(r_rd_addr) * ID_W'(WORD_BITS)) +
                                        ID_W'(found_bit);
                        r_state      <= ST_IDLE;
                    end else if (r_rd_addr == LAST_WORD) begin
                        r_valid      <= 1'b1;
                        r_exhausted  <= 1'b1;
                        r_granted_id <= '0;
                        r_state      <= ST_IDLE;
                    end
                end
                ST_FREE_DIV: begin
                    r_bit   <= BW'(rem_fix);
                    r_state <= ST_FREE_WR;
                end
                ST_FREE_WR: r_state <= ST_IDLE;
                default:    r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_granted_id = r_granted_id;
    assign o_exhausted  = r_exhausted;

`include "lowest_free_id_bitmap_allocator_core_assert.svh"

    `LFID_ASSERT_NOW(a_exhausted_id_zero, o_valid, o_exhausted == (o_granted_id == '0), "exhausted flag and granted id disagree")
    `LFID_ASSERT_NEXT(a_alloc_goes_busy, accept && (i_req_type == REQ_ALLOC), busy, "allocate did not start a scan")
    `LFID_ASSERT_NEXT(a_single_result, o_valid, !o_valid, "two results in consecutive cycles")
    `LFID_ASSERT_NOW(a_result_after_scan, o_valid, $past(r_state) == ST_SCAN, "result without a scan")

endmodule

`default_nettype wire
